// ===== rtl/relay_time_proportioning_pwm_unit_macros.svh =====
// assertion macros shared by the relay pwm rtl
`ifndef RELAY_TIME_PROPORTIONING_PWM_UNIT_MACROS_SVH
`define RELAY_TIME_PROPORTIONING_PWM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTPWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTPWM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RTPWM_ASSERT(label, prop, msg)
`define RTPWM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/rtpwm_pkg.sv =====
// types and constants of the relay time-proportioning pwm unit
package rtpwm_pkg;

  localparam int NUM_INPUTS   = 12;
  localparam int CHANNELS_DEF = 12;
  localparam int WORD_W       = 12;
  localparam int LEVEL_W      = 10;
  localparam int PERIOD_W     = 8;
  localparam int CNT_W        = 13;
  localparam int PROD_W       = CNT_W + LEVEL_W;
  localparam int THR_W        = CNT_W + 1 + LEVEL_W;
  localparam int CFG_W        = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int SMALL_LANES  = 6;
  localparam int TINY_OFF_LO  = 4;
  localparam int TINY_OFF_HI  = 5;
  localparam int SPAN_MUL     = 20;
  localparam int FULL_SCALE   = 1023;
  localparam logic [LEVEL_W-1:0] DIGITAL_ON = LEVEL_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOARD_VARIANT = 3'd0,
    REG_CHANNEL_MODES = 3'd1,
    REG_ANALOG_MASK   = 3'd2,
    REG_PERIODS_LOW   = 3'd3,
    REG_PERIODS_HIGH  = 3'd4,
    REG_RELAY_BASE    = 3'd5
  } reg_t;

  typedef enum logic [1:0] {
    VAR_BIG   = 2'd0,
    VAR_SMALL = 2'd1,
    VAR_TINY  = 2'd2
  } variant_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HAND = 2'd1,
    MODE_AUTO = 2'd2,
    MODE_HOLD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_CLEAR,
    ACT_SET,
    ACT_PWM
  } act_t;

  typedef struct packed {
    logic                active;
    logic                force_off;
    mode_t               mode;
    logic                analog;
    logic [PERIOD_W-1:0] period;
  } lane_ctl_t;

  typedef struct packed {
    logic drive;
    logic value;
  } lane_res_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_11;
    logic [LEVEL_W-1:0] level_10;
    logic [LEVEL_W-1:0] level_9;
    logic [LEVEL_W-1:0] level_8;
    logic [LEVEL_W-1:0] level_7;
    logic [LEVEL_W-1:0] level_6;
    logic [LEVEL_W-1:0] level_5;
    logic [LEVEL_W-1:0] level_4;
    logic [LEVEL_W-1:0] level_3;
    logic [LEVEL_W-1:0] level_2;
    logic [LEVEL_W-1:0] level_1;
    logic [LEVEL_W-1:0] level_0;
  } tick_t;

  typedef struct packed {
    logic [WORD_W-1:0] relay_word;
    logic              relay_changed;
  } relay_t;

endpackage

// ===== rtl/rtpwm_lane.sv =====
// one relay channel: mode decode, pwm counter and duty compare
module rtpwm_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  rtpwm_pkg::lane_ctl_t                ctl,
  input  logic [rtpwm_pkg::LEVEL_W-1:0]       level,
  output rtpwm_pkg::lane_res_t                res
);

`include "relay_time_proportioning_pwm_unit_macros.svh"

  logic [rtpwm_pkg::CNT_W-1:0]  cnt;
  logic [rtpwm_pkg::CNT_W-1:0]  cnt_next;
  logic [rtpwm_pkg::CNT_W-1:0]  span;
  logic [rtpwm_pkg::CNT_W-1:0]  cnt_s;
  logic [rtpwm_pkg::PROD_W-1:0] prod;
  logic [rtpwm_pkg::PROD_W-1:0] prod_s;
  logic [rtpwm_pkg::CNT_W:0]    inc;
  logic [rtpwm_pkg::THR_W-1:0]  thr;
  rtpwm_pkg::act_t              act_next;
  rtpwm_pkg::act_t              act;
  logic                         advance;

  assign span = rtpwm_pkg::CNT_W'(ctl.period) * rtpwm_pkg::CNT_W'(rtpwm_pkg::SPAN_MUL);
  assign prod = rtpwm_pkg::PROD_W'(span) * rtpwm_pkg::PROD_W'(level);

  always_comb begin
    act_next = rtpwm_pkg::ACT_HOLD;
    if (!ctl.active) begin
      act_next = rtpwm_pkg::ACT_HOLD;
    end else if (ctl.force_off) begin
      act_next = rtpwm_pkg::ACT_CLEAR;
    end else begin
      unique case (ctl.mode)
        rtpwm_pkg::MODE_OFF:  act_next = rtpwm_pkg::ACT_CLEAR;
        rtpwm_pkg::MODE_HAND: act_next = rtpwm_pkg::ACT_SET;
        rtpwm_pkg::MODE_AUTO: begin
          if (ctl.analog) begin
            act_next = rtpwm_pkg::ACT_PWM;
          end else if (level >= rtpwm_pkg::DIGITAL_ON) begin
            act_next = rtpwm_pkg::ACT_SET;
          end else begin
            act_next = rtpwm_pkg::ACT_CLEAR;
          end
        end
        rtpwm_pkg::MODE_HOLD: act_next = rtpwm_pkg::ACT_HOLD;
        default:              act_next = rtpwm_pkg::ACT_HOLD;
      endcase
    end
  end

  // counter only runs in auto analog
  assign advance  = take && (act_next == rtpwm_pkg::ACT_PWM);
  assign cnt_next = (cnt < span) ? cnt + rtpwm_pkg::CNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      act <= rtpwm_pkg::ACT_HOLD;
    end else begin
      if (advance) begin
        cnt <= cnt_next;
      end
      if (take) begin
        act <= act_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cnt_s  <= cnt_next;
      prod_s <= prod;
    end
  end

  // cnt < floor(prod / 1023) is the same as (cnt + 1) * 1023 <= prod
  assign inc = {1'b0, cnt_s} + (rtpwm_pkg::CNT_W + 1)'(1);
  assign thr = rtpwm_pkg::THR_W'(inc) * rtpwm_pkg::THR_W'(rtpwm_pkg::FULL_SCALE);

  always_comb begin
    unique case (act)
      rtpwm_pkg::ACT_HOLD:  res = '{drive: 1'b0, value: 1'b0};
      rtpwm_pkg::ACT_CLEAR: res = '{drive: 1'b1, value: 1'b0};
      rtpwm_pkg::ACT_SET:   res = '{drive: 1'b1, value: 1'b1};
      rtpwm_pkg::ACT_PWM:   res = '{drive: 1'b1, value: (thr <= {1'b0, prod_s})};
      default:              res = '{drive: 1'b0, value: 1'b0};
    endcase
  end

  `RTPWM_ASSERT_NEXT(a_cnt_in_span, advance, cnt <= $past(span), "pwm counter ran past its span")

endmodule

// ===== rtl/rtpwm_merge.sv =====
// merges lane decisions into the relay word and holds the output register
module rtpwm_merge #(
  parameter int LANES = rtpwm_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [1:0]                        variant,
  input  logic [rtpwm_pkg::WORD_W-1:0]      base_word,
  input  rtpwm_pkg::lane_res_t [LANES-1:0]  lanes,
  input  logic                              relay_ready,
  output logic                              relay_valid,
  output rtpwm_pkg::relay_t                 relay
);

`include "relay_time_proportioning_pwm_unit_macros.svh"

  logic [rtpwm_pkg::WORD_W-1:0] last_word;
  logic [rtpwm_pkg::WORD_W-1:0] word_next;

  // undefined variant drives no lane, so the word stays and changed is 0
  always_comb begin
    word_next = (variant == rtpwm_pkg::VAR_BIG) ? base_word : last_word;
    for (int n = 0; n < LANES; n++) begin
      if (lanes[n].drive) begin
        word_next[n] = lanes[n].value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_valid <= 1'b0;
      last_word   <= '0;
    end else begin
      if (load) begin
        relay_valid <= 1'b1;
        last_word   <= word_next;
      end else if (relay_ready) begin
        relay_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      relay.relay_word    <= word_next;
      relay.relay_changed <= (word_next != last_word);
    end
  end

  `RTPWM_ASSERT_NEXT(a_last_tracks_out, load, last_word == relay.relay_word, "last word lost")
  `RTPWM_ASSERT_NEXT(a_changed_flag, load, relay.relay_changed == (relay.relay_word != $past(last_word)), "changed flag wrong")

endmodule

// ===== rtl/relay_time_proportioning_pwm_unit.sv =====
// Relay driver with time-proportioning slow pwm, one lane per channel.
// Takes one refresh tick per clock cycle while tick_ready is high. The lane
// registers (decoded action, the updated pwm counter and the span times level
// product) load at the edge that accepts the tick, and the merged relay word waits
// for a free output register. The lane stage and the output register form a
// two-deep pipeline, so a stalled receiver holds two ticks before the input
// stalls. Reset clears all configuration registers, pwm counters and the previous
// word. Configuration writes take effect at once and belong only in idle periods.
module relay_time_proportioning_pwm_unit #(
  parameter int CHANNELS = rtpwm_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  rtpwm_pkg::tick_t                    tick,
  output logic                                relay_valid,
  input  logic                                relay_ready,
  output rtpwm_pkg::relay_t                   relay,
  input  logic                                cfg_we,
  input  logic [rtpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpwm_pkg::CFG_W-1:0]         cfg_data
);

`include "relay_time_proportioning_pwm_unit_macros.svh"

  localparam int NLANES = (CHANNELS < rtpwm_pkg::WORD_W) ? CHANNELS : rtpwm_pkg::WORD_W;

  logic [1:0]                          board_variant;
  logic [2*rtpwm_pkg::WORD_W-1:0]      channel_modes;
  logic [rtpwm_pkg::WORD_W-1:0]        analog_mask;
  logic [rtpwm_pkg::CFG_W-1:0]         periods_low;
  logic [rtpwm_pkg::CFG_W-1:0]         periods_high;
  logic [rtpwm_pkg::WORD_W-1:0]        relay_base_word;
  logic [2*rtpwm_pkg::CFG_W-1:0]       periods;

  logic                                s1_valid;
  logic                                take;
  logic                                load;
  logic [rtpwm_pkg::LEVEL_W-1:0]       levels [rtpwm_pkg::NUM_INPUTS];
  rtpwm_pkg::lane_ctl_t [NLANES-1:0]   ctl;
  rtpwm_pkg::lane_res_t [NLANES-1:0]   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_variant   <= '0;
      channel_modes   <= '0;
      analog_mask     <= '0;
      periods_low     <= '0;
      periods_high    <= '0;
      relay_base_word <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtpwm_pkg::REG_BOARD_VARIANT: board_variant   <= cfg_data[1:0];
        rtpwm_pkg::REG_CHANNEL_MODES: channel_modes   <= cfg_data[2*rtpwm_pkg::WORD_W-1:0];
        rtpwm_pkg::REG_ANALOG_MASK:   analog_mask     <= cfg_data[rtpwm_pkg::WORD_W-1:0];
        rtpwm_pkg::REG_PERIODS_LOW:   periods_low     <= cfg_data;
        rtpwm_pkg::REG_PERIODS_HIGH:  periods_high    <= cfg_data;
        rtpwm_pkg::REG_RELAY_BASE:    relay_base_word <= cfg_data[rtpwm_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // period byte n of all twelve channels in one vector
  assign periods = {periods_high, periods_low};

  assign levels[0]  = tick.level_0;
  assign levels[1]  = tick.level_1;
  assign levels[2]  = tick.level_2;
  assign levels[3]  = tick.level_3;
  assign levels[4]  = tick.level_4;
  assign levels[5]  = tick.level_5;
  assign levels[6]  = tick.level_6;
  assign levels[7]  = tick.level_7;
  assign levels[8]  = tick.level_8;
  assign levels[9]  = tick.level_9;
  assign levels[10] = tick.level_10;
  assign levels[11] = tick.level_11;

  // lane stage register feeds the output register
  assign load       = s1_valid && (!relay_valid || relay_ready);
  assign tick_ready = !s1_valid || load;
  assign take       = tick_valid && tick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  for (genvar n = 0; n < NLANES; n++) begin : g_lane
    localparam bit IN_SMALL = (n < rtpwm_pkg::SMALL_LANES);
    localparam bit TINY_OFF = (n == rtpwm_pkg::TINY_OFF_LO) || (n == rtpwm_pkg::TINY_OFF_HI);

    always_comb begin
      ctl[n].mode   = rtpwm_pkg::mode_t'(channel_modes[2*n +: 2]);
      ctl[n].analog = analog_mask[n];
      ctl[n].period = periods[rtpwm_pkg::PERIOD_W*n +: rtpwm_pkg::PERIOD_W];
      ctl[n].force_off = (board_variant == rtpwm_pkg::VAR_TINY) && TINY_OFF && analog_mask[n];
      unique case (board_variant) inside
        rtpwm_pkg::VAR_BIG:                     ctl[n].active = 1'b1;
        rtpwm_pkg::VAR_SMALL, rtpwm_pkg::VAR_TINY: ctl[n].active = IN_SMALL;
        default:                                ctl[n].active = 1'b0;
      endcase
    end

    rtpwm_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .take  (take),
      .ctl   (ctl[n]),
      .level (levels[n]),
      .res   (res[n])
    );
  end

  rtpwm_merge #(
    .LANES (NLANES)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .variant     (board_variant),
    .base_word   (relay_base_word),
    .lanes       (res),
    .relay_ready (relay_ready),
    .relay_valid (relay_valid),
    .relay       (relay)
  );

  `RTPWM_ASSERT_NEXT(a_take_fills_stage, take, s1_valid, "accepted tick not held in lane stage")
  `RTPWM_ASSERT(a_no_take_when_full, !(take && s1_valid && !load), "tick taken over a full stage")

endmodule
